// ===== rtl/wes_pkg.sv =====
// Shared constants, types and register codes for the wave equation stencil step.
`default_nettype none

package wes_pkg;

   // Field widths
   localparam int DATA_W       = 32;
   localparam int GRID_W       = 6;
   localparam int COEF_W       = 18;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 18;

   // Grid limits and register reset values
   localparam int MAX_GRID_DEF = 64;
   localparam int GRID_MIN     = 2;
   localparam int GRID_MAX     = (1 << GRID_W) - 1;
   localparam int GRID_RESET   = 10;
   localparam int COEF_RESET   = 32768;

   // Arithmetic widths (Q16.16 data, Q2.16 coefficients)
   localparam int FRAC_BITS    = 16;
   localparam int LAP_W        = DATA_W + 3;
   localparam int BASE_W       = DATA_W + 2;
   localparam int PROD_W       = COEF_W + 1 + LAP_W;
   localparam int TERM_W       = PROD_W + 1;
   localparam int SUM_W        = TERM_W - FRAC_BITS + 1;
   localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);

   // Result queue
   localparam int SLOTS        = 4;
   localparam int SLOT_CNT_W   = 3;
   localparam int Q_DEPTH      = 16;
   localparam int Q_IDX_W      = 4;
   localparam int Q_CNT_W      = 5;

   // Window columns held in the cell chain
   localparam int WIN_COLS     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_LAST  = 2'd0,
      CSR_COEF_X     = 2'd1,
      CSR_COEF_Y     = 2'd2,
      CSR_FIRST_STEP = 2'd3
   } wes_csr_type;

   // One window column: rows r-2, r-1, r of the current field, row r-1 of the previous
   typedef struct packed {
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] mid;
      logic [DATA_W-1:0] bot;
      logic [DATA_W-1:0] prv;
   } wes_col_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [GRID_W-1:0] row;
      logic [GRID_W-1:0] col;
      logic              last;
   } wes_result_type;

   // All results caused by one item, packed from slot 0
   typedef struct packed {
      logic [SLOT_CNT_W-1:0]       count;
      wes_result_type [SLOTS-1:0]  slot;
   } wes_bundle_type;

   // Operands handed to the arithmetic pipeline
   typedef struct packed {
      logic signed [LAP_W-1:0]  lap_x;
      logic signed [LAP_W-1:0]  lap_y;
      logic signed [BASE_W-1:0] base;
      logic                     interior;
      wes_bundle_type           bundle;
   } wes_op_type;

endpackage

`default_nettype wire

// ===== rtl/wes_line.sv =====
// One line buffer: single write port, registered read port.
`default_nettype none

module wes_line
   import wes_pkg::*;
#(
   parameter int DEPTH = MAX_GRID_DEF,
   parameter int AW    = $clog2(MAX_GRID_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/wes_cell.sv =====
// Window cell: holds one stencil column and passes it to the next cell on each item.
`default_nettype none

module wes_cell
   import wes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        shift,
   input  wire wes_col_type load_col,
   output      wes_col_type held_col
);

   wes_col_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= load_col;
      end
   end

   assign held_col = col_ff;

endmodule

`default_nettype wire

// ===== rtl/wes_core.sv =====
// Arithmetic pipeline: coefficient products, rounding, base add and saturation.
`default_nettype none

module wes_core
   import wes_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   input  wire wes_op_type        op,
   input  wire logic [COEF_W-1:0] coef_x,
   input  wire logic [COEF_W-1:0] coef_y,
   output      logic              push_valid,
   output      wes_bundle_type    push_bundle
);

   // Stage 1: operands
   logic       s1_valid_ff;
   wes_op_type s1_op_ff;

   // Stage 2: products
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_prod_x_ff;
   logic signed [PROD_W-1:0] s2_prod_y_ff;
   logic signed [PROD_W-1:0] s2_prod_x_in;
   logic signed [PROD_W-1:0] s2_prod_y_in;
   logic signed [BASE_W-1:0] s2_base_ff;
   logic                     s2_interior_ff;
   wes_bundle_type           s2_bundle_ff;

   // Stage 3: rounded terms
   logic                     s3_valid_ff;
   logic signed [TERM_W-1:0] s3_term_ff;
   logic signed [TERM_W-1:0] s3_term_in;
   logic signed [BASE_W-1:0] s3_base_ff;
   logic                     s3_interior_ff;
   wes_bundle_type           s3_bundle_ff;

   logic signed [TERM_W-FRAC_BITS-1:0] rounded;
   logic signed [SUM_W-1:0]            sum;
   logic [DATA_W-1:0]                  sat_value;

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= op_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Coefficients are unsigned Q2.16
   assign s2_prod_x_in = $signed({1'b0, coef_x}) * s1_op_ff.lap_x;
   assign s2_prod_y_in = $signed({1'b0, coef_y}) * s1_op_ff.lap_y;

   // Sum of products plus one half LSB of the result
   assign s3_term_in = TERM_W'(s2_prod_x_ff) + TERM_W'(s2_prod_y_ff)
                       + TERM_W'(ROUND_HALF);

   // Payload pipeline
   always_ff @(posedge clock) begin
      s1_op_ff       <= op;
      s2_prod_x_ff   <= s2_prod_x_in;
      s2_prod_y_ff   <= s2_prod_y_in;
      s2_base_ff     <= s1_op_ff.base;
      s2_interior_ff <= s1_op_ff.interior;
      s2_bundle_ff   <= s1_op_ff.bundle;
      s3_term_ff     <= s3_term_in;
      s3_base_ff     <= s2_base_ff;
      s3_interior_ff <= s2_interior_ff;
      s3_bundle_ff   <= s2_bundle_ff;
   end

   // Floor to Q16.16, add base, clamp to 32 bits
   always_comb begin
      rounded = s3_term_ff[TERM_W-1:FRAC_BITS];
      sum     = SUM_W'(s3_base_ff) + SUM_W'(rounded);
      if (&sum[SUM_W-1:DATA_W-1] || ~|sum[SUM_W-1:DATA_W-1]) begin
         sat_value = sum[DATA_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_comb begin
      push_bundle = s3_bundle_ff;
      if (s3_interior_ff) begin
         push_bundle.slot[0].value = sat_value;
      end
   end

   assign push_valid = s3_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/wes_queue.sv =====
// Result queue: takes up to four results per cycle, gives one per cycle when popped.
`default_nettype none

module wes_queue
   import wes_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   input  wire wes_bundle_type push_bundle,
   input  wire logic           pop,
   output      logic           head_valid,
   output      wes_result_type head
);

   wes_result_type       entry_ff [Q_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ptr_ff;
   logic [Q_IDX_W-1:0]   wr_ptr_in;
   logic [Q_IDX_W-1:0]   rd_ptr_ff;
   logic [Q_IDX_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;
   logic [SLOT_CNT_W-1:0] push_n;

   assign push_n    = push_valid ? push_bundle.count : '0;
   assign wr_ptr_in = wr_ptr_ff + Q_IDX_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + Q_IDX_W'(pop);
   assign count_in  = count_ff + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item's results in order
   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS; k++) begin
         if (SLOT_CNT_W'(k) < push_n) begin
            entry_ff[Q_IDX_W'(wr_ptr_ff + Q_IDX_W'(k))] <= push_bundle.slot[k];
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/wave_equation_stencil_step.sv =====
// Top level of the streaming 2D wave equation time step.
//
// Takes one grid sample (current and previous field, Q16.16) per clock in raster order and
// returns the next field per point, also in Q16.16, one result per clock while rsp_stall is
// low. A sample enters every clock as long as at most 12 results are held in the
// three-stage arithmetic pipeline and the 16-entry result queue; the queue drains one
// result per clock while rsp_stall is low, so with the output unstalled the input stalls
// only where the last column and the last row make two to four results per sample and
// the output falls behind. The stencil window is a chain of two column cells fed by three
// line buffers with registered reads; the line buffers are not cleared, so after reset or
// a new grid size the first two rows only produce boundary zeros until real data has
// passed through. Writing grid_last restarts the raster at row 0, column 0.
`default_nettype none

module wave_equation_stencil_step
   import wes_pkg::*;
#(
   parameter int MAX_GRID = MAX_GRID_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Configuration
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   // Samples
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic signed [DATA_W-1:0] req_cur_value,
   input  wire logic signed [DATA_W-1:0] req_prev_value,
   // Results
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [DATA_W-1:0] rsp_next_value,
   output      logic [GRID_W-1:0]        rsp_out_row,
   output      logic [GRID_W-1:0]        rsp_out_col,
   output      logic                     rsp_last
);

   localparam int AW         = $clog2(MAX_GRID);
   localparam int LAST_MAX_I = (MAX_GRID - 1 > GRID_MAX) ? GRID_MAX : MAX_GRID - 1;
   localparam logic [GRID_W-1:0] LAST_MAX = GRID_W'(LAST_MAX_I);

   // Configuration registers
   logic [GRID_W-1:0] grid_last_ff;
   logic [COEF_W-1:0] coef_x_ff;
   logic [COEF_W-1:0] coef_y_ff;
   logic              first_step_ff;
   logic              grid_write;

   // Raster position and result credits
   logic [GRID_W-1:0]  row_ff;
   logic [GRID_W-1:0]  row_in;
   logic [GRID_W-1:0]  col_ff;
   logic [GRID_W-1:0]  col_in;
   logic [Q_CNT_W-1:0] used_ff;
   logic [Q_CNT_W-1:0] used_in;

   logic              accept;
   logic              pop;
   logic [GRID_W-1:0] g_last;

   // Line buffer reads (column c of rows r-2, r-1 and previous field row r-1)
   logic [DATA_W-1:0] upper_rd;
   logic [DATA_W-1:0] lower_rd;
   logic [DATA_W-1:0] prev_rd;

   wes_col_type cell_feed [WIN_COLS];
   wes_col_type win_col   [WIN_COLS];

   logic signed [DATA_W-1:0] w_up;
   logic signed [DATA_W-1:0] w_mid;
   logic signed [DATA_W-1:0] w_dn;
   logic signed [DATA_W-1:0] w_lf;
   logic signed [DATA_W-1:0] w_rt;
   logic signed [DATA_W-1:0] w_pv;

   logic has_a;
   logic has_b;
   logic has_c;
   logic has_d;

   wes_op_type     op;
   logic           push_valid;
   wes_bundle_type push_bundle;
   wes_result_type head;

   assign accept     = req_valid && !req_stall;
   assign pop        = rsp_valid && !rsp_stall;
   assign grid_write = csr_write && (wes_csr_type'(csr_index) == CSR_GRID_LAST);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_last_ff  <= GRID_W'(GRID_RESET);
         coef_x_ff     <= COEF_W'(COEF_RESET);
         coef_y_ff     <= COEF_W'(COEF_RESET);
         first_step_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (wes_csr_type'(csr_index))
            CSR_GRID_LAST:  grid_last_ff  <= csr_data[GRID_W-1:0];
            CSR_COEF_X:     coef_x_ff     <= csr_data[COEF_W-1:0];
            CSR_COEF_Y:     coef_y_ff     <= csr_data[COEF_W-1:0];
            CSR_FIRST_STEP: first_step_ff <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // Effective last index, clamped to the supported range
   always_comb begin
      if (grid_last_ff < GRID_W'(GRID_MIN)) begin
         g_last = GRID_W'(GRID_MIN);
      end else if (grid_last_ff > LAST_MAX) begin
         g_last = LAST_MAX;
      end else begin
         g_last = grid_last_ff;
      end
   end

   // Raster counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (grid_write) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_ff == g_last) begin
            col_in = '0;
            row_in = (row_ff == g_last) ? '0 : row_ff + GRID_W'(1);
         end else begin
            col_in = col_ff + GRID_W'(1);
         end
      end
   end

   // Results in flight or queued; leave room for a full item
   assign used_in   = used_ff + (accept ? Q_CNT_W'(op.bundle.count) : '0) - Q_CNT_W'(pop);
   assign req_stall = (used_ff > Q_CNT_W'(Q_DEPTH - SLOTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         used_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         used_ff <= used_in;
      end
   end

   // Line buffers: read ahead at the next column, write the current one
   wes_line #(.DEPTH(MAX_GRID), .AW(AW)) u_line_upper (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (AW'(col_ff)),
      .wr_data (lower_rd),
      .rd_addr (AW'(col_in)),
      .rd_data (upper_rd)
   );

   wes_line #(.DEPTH(MAX_GRID), .AW(AW)) u_line_lower (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (AW'(col_ff)),
      .wr_data (req_cur_value),
      .rd_addr (AW'(col_in)),
      .rd_data (lower_rd)
   );

   wes_line #(.DEPTH(MAX_GRID), .AW(AW)) u_line_prev (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (AW'(col_ff)),
      .wr_data (req_prev_value),
      .rd_addr (AW'(col_in)),
      .rd_data (prev_rd)
   );

   // Window cell chain: cell 0 holds column c-1, cell 1 column c-2
   assign cell_feed[0] = '{top: upper_rd, mid: lower_rd, bot: req_cur_value, prv: prev_rd};

   for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign cell_feed[k] = win_col[k-1];
      end
      wes_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (accept),
         .load_col (cell_feed[k]),
         .held_col (win_col[k])
      );
   end

   assign w_up  = win_col[0].top;
   assign w_mid = win_col[0].mid;
   assign w_dn  = win_col[0].bot;
   assign w_pv  = win_col[0].prv;
   assign w_lf  = win_col[1].mid;
   assign w_rt  = lower_rd;

   // Which results this sample produces
   assign has_a = (row_ff != '0) && (col_ff != '0);
   assign has_b = (col_ff == g_last) && (row_ff != '0);
   assign has_c = (row_ff == g_last) && (col_ff != '0);
   assign has_d = (row_ff == g_last) && (col_ff == g_last);

   // Operands and result slots for the arithmetic pipeline
   always_comb begin
      op.lap_x = LAP_W'(w_up) + LAP_W'(w_dn) - (LAP_W'(w_mid) <<< 1);
      op.lap_y = LAP_W'(w_lf) + LAP_W'(w_rt) - (LAP_W'(w_mid) <<< 1);
      if (first_step_ff) begin
         op.base = BASE_W'(w_mid);
      end else begin
         op.base = (BASE_W'(w_mid) <<< 1) - BASE_W'(w_pv);
      end
      op.interior = (row_ff >= GRID_W'(2)) && (col_ff >= GRID_W'(2));

      op.bundle.count = SLOT_CNT_W'(has_a) + SLOT_CNT_W'(has_b)
                        + SLOT_CNT_W'(has_c) + SLOT_CNT_W'(has_d);
      op.bundle.slot  = '0;

      // Point one row up and one column left of the sample
      op.bundle.slot[0].row = row_ff - GRID_W'(1);
      op.bundle.slot[0].col = col_ff - GRID_W'(1);
      // Last column point, else last row point
      if (has_b) begin
         op.bundle.slot[1].row = row_ff - GRID_W'(1);
         op.bundle.slot[1].col = g_last;
      end else begin
         op.bundle.slot[1].row = g_last;
         op.bundle.slot[1].col = col_ff - GRID_W'(1);
      end
      // Final sample: last row point then corner
      op.bundle.slot[2].row = g_last;
      op.bundle.slot[2].col = col_ff - GRID_W'(1);
      op.bundle.slot[3].row = g_last;
      op.bundle.slot[3].col = g_last;

      for (int k = 0; k < SLOTS; k++) begin
         op.bundle.slot[k].last = (SLOT_CNT_W'(k + 1) == op.bundle.count);
      end
   end

   wes_core u_core (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (accept),
      .op          (op),
      .coef_x      (coef_x_ff),
      .coef_y      (coef_y_ff),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   wes_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head_valid  (rsp_valid),
      .head        (head)
   );

   assign rsp_next_value = head.value;
   assign rsp_out_row    = head.row;
   assign rsp_out_col    = head.col;
   assign rsp_last       = head.last;

endmodule

`default_nettype wire
